// ===== sv/hbcd_pkg.sv =====
// Package for the hashed buffer cache directory.
// Request and response payload types, directory entry type and command/status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbcd_pkg;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_PIN     = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [1:0] ST_HIT       = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  device_id;
        logic [31:0] block_number;
        logic [3:0]  slot_bucket;
        logic [1:0]  slot_way;
        logic [31:0] now_tick;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] out_bucket;
        logic [1:0] out_way;
        logic       needs_read;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic        valid;
        logic [7:0]  count;
        logic [31:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/hashed_buffer_cache_directory.sv =====
// Hashed buffer cache directory: bucket memory, hash unit, lookup/replacement sequencer.
// Depends on hbcd_pkg.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+----------------
//   req     | in  | req_valid / req_stall  | hbcd_pkg::req_t
//   rsp     | out | rsp_valid / rsp_stall  | hbcd_pkg::rsp_t
//
// One item at a time. Release/pin/unknown go through row read, lookup and write-back.
// Get adds the block-number-modulo-BUCKETS hash before the row read, one byte per step,
// and on a miss a victim search after the lookup that visits one way per cycle.
// Each bucket is one memory row, read through a register and written back whole.
// Reset clears per-bucket valid flags at once; a bucket never written reads as zero.
// A stalled response holds in the output register; the next request is still taken.
`timescale 1ns / 1ps
`default_nettype none

module hashed_buffer_cache_directory #(
    parameter int BUCKETS = 13,
    parameter int WAYS    = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire hbcd_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output hbcd_pkg::rsp_t     rsp
);
    import hbcd_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [BW+7:0] BMOD = (BW+8)'(BUCKETS);

    typedef entry_t [WAYS-1:0] row_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HASH   = 6'b000010,
        S_READ   = 6'b000100,
        S_LOOK   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    // one restoring step of (256*r + b) mod BUCKETS, r already reduced
    function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r, input logic [7:0] b);
        logic [BW+7:0] v;
        v = {r, b};
        for (int k = 7; k >= 0; k--) begin
            if (v >= (BMOD << k))
                v = v - (BMOD << k);
        end
        return v[BW-1:0];
    endfunction

    function automatic logic slot_ok(input logic [3:0] b, input logic [1:0] w);
        return (7'(b) < 7'(BUCKETS)) && (5'(w) < 5'(WAYS));
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == COUNT_MAX) ? c : c + 8'd1;
    endfunction

    state_t          state_reg, state_next;
    req_t            req_reg, req_next;
    logic [BW-1:0]   row_reg, row_next;
    logic [1:0]      hash_cnt_reg, hash_cnt_next;
    logic [WW-1:0]   scan_way_reg, scan_way_next;
    logic            found_reg, found_next;
    logic [31:0]     best_reg, best_next;
    logic [WW-1:0]   pick_reg, pick_next;
    logic            wr_en_reg, wr_en_next;
    row_t            wr_row_reg, wr_row_next;
    rsp_t            res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg;
    logic [BUCKETS-1:0] row_init_reg;

    row_t            mem [BUCKETS];
    row_t            rd_data_reg;
    logic            rd_init_reg;
    row_t            cur_row;

    logic            out_load;
    logic            mem_we;
    logic            hit;
    logic [WW-1:0]   hit_way;
    logic            take;
    logic            fin_found;
    logic [WW-1:0]   fin_pick;
    logic [WW-1:0]   slot_wi;
    entry_t          e;

    assign cur_row   = rd_init_reg ? rd_data_reg : '0;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_load  = (state_reg == S_FINISH) && !(out_valid_reg && rsp_stall);
    assign mem_we    = out_load && wr_en_reg;
    assign slot_wi   = WW'(req_reg.slot_way);

    // tag match ignores valid; lowest way wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (cur_row[w].device == req_reg.device_id && cur_row[w].block == req_reg.block_number)
            begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
        end
    end

    always_comb
    begin
        take      = (cur_row[scan_way_reg].count == 8'd0) &&
                    (!found_reg || cur_row[scan_way_reg].stamp < best_reg);
        fin_found = found_reg || take;
        fin_pick  = take ? scan_way_reg : pick_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        row_next       = row_reg;
        hash_cnt_next  = hash_cnt_reg;
        scan_way_next  = scan_way_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        wr_en_next     = wr_en_reg;
        wr_row_next    = wr_row_reg;
        res_next       = res_reg;
        e              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    hash_cnt_next = '0;
                    if (req.command == CMD_GET)
                    begin
                        row_next   = '0;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        row_next = (req.command != CMD_NONE &&
                                    slot_ok(req.slot_bucket, req.slot_way))
                                   ? BW'(req.slot_bucket) : '0;
                        state_next = S_READ;
                    end
                end
            end
            S_HASH:
            begin
                // most significant byte first
                row_next      = mod_step(row_reg, req_reg.block_number[{~hash_cnt_reg, 3'b000} +: 8]);
                hash_cnt_next = hash_cnt_reg + 2'd1;
                if (hash_cnt_reg == 2'd3)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                wr_en_next  = 1'b0;
                wr_row_next = cur_row;
                res_next    = '{status: ST_HIT, out_bucket: 4'(row_reg), out_way: 2'd0,
                                needs_read: 1'b0};
                state_next  = S_FINISH;
                unique case (req_reg.command)
                    CMD_GET:
                    begin
                        if (hit)
                        begin
                            e        = cur_row[hit_way];
                            e.count  = sat_inc(e.count);
                            e.stamp  = req_reg.now_tick;
                            e.valid  = 1'b1;
                            wr_row_next[hit_way] = e;
                            wr_en_next           = 1'b1;
                            res_next.out_way     = 2'(hit_way);
                            res_next.needs_read  = !cur_row[hit_way].valid;
                        end
                        else
                        begin
                            found_next    = 1'b0;
                            best_next     = '0;
                            pick_next     = '0;
                            scan_way_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    CMD_RELEASE, CMD_PIN:
                    begin
                        res_next.out_bucket = req_reg.slot_bucket;
                        res_next.out_way    = req_reg.slot_way;
                        if (slot_ok(req_reg.slot_bucket, req_reg.slot_way))
                        begin
                            e = cur_row[slot_wi];
                            if (req_reg.command == CMD_PIN)
                            begin
                                e.count    = sat_inc(e.count);
                                wr_en_next = 1'b1;
                            end
                            else if (e.count == 8'd0)
                                res_next.status = ST_UNDERFLOW;
                            else
                            begin
                                e.count    = e.count - 8'd1;
                                wr_en_next = 1'b1;
                            end
                            wr_row_next[slot_wi] = e;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                    best_next  = cur_row[scan_way_reg].stamp;
                    pick_next  = scan_way_reg;
                end
                scan_way_next = scan_way_reg + WW'(1);
                if (scan_way_reg == WW'(WAYS - 1))
                begin
                    state_next = S_FINISH;
                    if (fin_found)
                    begin
                        e = '{device: req_reg.device_id, block: req_reg.block_number,
                              valid: 1'b1, count: 8'd1, stamp: req_reg.now_tick};
                        wr_row_next[fin_pick] = e;
                        wr_en_next            = 1'b1;
                        res_next.status       = ST_MISS;
                        res_next.out_way      = 2'(fin_pick);
                        res_next.needs_read   = 1'b1;
                    end
                    else
                    begin
                        wr_en_next          = 1'b0;
                        res_next.status     = ST_NO_FREE;
                        res_next.out_way    = 2'd0;
                        res_next.needs_read = 1'b0;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_init_reg  <= '0;
            hash_cnt_reg  <= '0;
            scan_way_reg  <= '0;
            found_reg     <= 1'b0;
            wr_en_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hash_cnt_reg  <= hash_cnt_next;
            scan_way_reg  <= scan_way_next;
            found_reg     <= found_next;
            wr_en_reg     <= wr_en_next;
            if (mem_we)
                row_init_reg[row_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        row_reg    <= row_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        wr_row_reg <= wr_row_next;
        res_reg    <= res_next;
        if (out_load)
            out_reg <= res_reg;
    end

    // bucket memory: one row per bucket, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[row_reg] <= wr_row_reg;
        rd_data_reg <= mem[row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_init_reg <= 1'b0;
        else
            rd_init_reg <= row_init_reg[row_reg];
    end

    a_hash_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (7'(row_reg) < 7'(BUCKETS)))
        else $error("bucket index out of range after hash");

    a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while busy");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && rsp_stall) |=>
        (state_reg == S_FINISH && $stable(res_reg)))
        else $error("result lost while output stalled");

    a_miss_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_reg.status == ST_MISS) |-> (wr_en_reg && res_reg.needs_read))
        else $error("miss without allocation or read flag");

    a_nofree_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_reg.status == ST_NO_FREE || res_reg.status == ST_UNDERFLOW))
        |-> !mem_we)
        else $error("directory written on a failed command");

endmodule

`default_nettype wire
